@@ design/pibc_pkg.sv @@
// Shared types, constants and saturation helpers for the PI back-calculation controller.
package pibc_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int INTEG_W   = 48;
    localparam int AI_FRAC   = 30;
    localparam int SUM_W     = INTEG_W + 2;
    localparam int OVR_W     = SUM_W + 1;
    localparam int MUL_A_W   = OVR_W + 1;
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ADDR_W    = 3;
    localparam int LIM_W     = 2;

    localparam logic [ADDR_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [ADDR_W-1:0] REG_AW_GAIN    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_UPPER      = 3'd3;
    localparam logic [ADDR_W-1:0] REG_LOWER      = 3'd4;

    localparam logic [LIM_W-1:0] LIM_NONE  = 2'd0;
    localparam logic [LIM_W-1:0] LIM_UPPER = 2'd1;
    localparam logic [LIM_W-1:0] LIM_LOWER = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured_value;
        logic signed [DATA_W-1:0] target_value;
        logic signed [DATA_W-1:0] feedforward_term;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_value;
        logic [LIM_W-1:0]         limit_state;
    } t_out_word;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
        logic                      frac30;
        logic                      wide;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [INTEG_W-1:0] result;
    } t_mul_rsp;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[DATA_W+1:DATA_W-1]) || !(|v[DATA_W+1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else if (v[DATA_W+1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [INTEG_W:0] v);
        logic signed [INTEG_W-1:0] r;
        if (v[INTEG_W] == v[INTEG_W-1]) begin
            r = v[INTEG_W-1:0];
        end else if (v[INTEG_W]) begin
            r = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(INTEG_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ design/pibc_mul.sv @@
// Multi-cycle sign-magnitude multiply, floor shift and saturate unit.
module pibc_mul
    import pibc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int HI_W = MUL_A_W - MUL_B_W;
    localparam logic [PROD_W-1:0] RND_AI = PROD_W'((64'd1 << AI_FRAC) - 64'd1);
    localparam logic [PROD_W-1:0] RND_FR = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_RND,
        M_FIN
    } t_mstate;

    t_mstate                   r_state;
    logic                      r_neg;
    logic [MUL_A_W-1:0]        r_mag;
    logic [MUL_B_W-1:0]        r_b;
    logic                      r_frac30;
    logic                      r_wide;
    logic [PROD_W-1:0]         r_acc;
    logic                      r_done;
    logic signed [INTEG_W-1:0] r_result;

    logic [2*MUL_B_W-1:0]      lo_prod;
    logic [HI_W+MUL_B_W-1:0]   hi_prod;
    logic [PROD_W-1:0]         shifted;
    logic [INTEG_W:0]          lim;
    logic [INTEG_W:0]          sat_mag;
    logic [INTEG_W:0]          neg_mag;

    assign lo_prod = (2*MUL_B_W)'(r_mag[MUL_B_W-1:0]) * (2*MUL_B_W)'(r_b);
    assign hi_prod = (HI_W+MUL_B_W)'(r_mag[MUL_A_W-1:MUL_B_W]) * (HI_W+MUL_B_W)'(r_b);

    always_comb begin
        shifted = r_frac30 ? (r_acc >> AI_FRAC) : (r_acc >> FRAC_BITS);
        lim     = (INTEG_W+1)'(1) << (r_wide ? (INTEG_W - 1) : (DATA_W - 1));
        if (!r_neg) begin
            lim = lim - (INTEG_W+1)'(1);
        end
        sat_mag = (shifted > PROD_W'(lim)) ? lim : shifted[INTEG_W:0];
        neg_mag = (~sat_mag) + (INTEG_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == M_FIN);
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_neg    <= i_req.a[MUL_A_W-1];
                        r_mag    <= i_req.a[MUL_A_W-1] ? (~i_req.a) + MUL_A_W'(1) : i_req.a;
                        r_b      <= i_req.b;
                        r_frac30 <= i_req.frac30;
                        r_wide   <= i_req.wide;
                        r_state  <= M_LO;
                    end
                end
                M_LO: begin
                    r_acc   <= PROD_W'(lo_prod);
                    r_state <= M_HI;
                end
                M_HI: begin
                    r_acc   <= r_acc + {hi_prod, {MUL_B_W{1'b0}}};
                    r_state <= M_RND;
                end
                M_RND: begin
                    if (r_neg) begin
                        r_acc <= r_acc + (r_frac30 ? RND_AI : RND_FR);
                    end
                    r_state <= M_FIN;
                end
                M_FIN: begin
                    r_result <= r_neg ? neg_mag[INTEG_W-1:0] : sat_mag[INTEG_W-1:0];
                    r_state  <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

@@ design/pi_controller_back_calc_antiwindup.sv @@
// PI controller with back-calculation anti-windup: sequencer, state and ports.
//
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_ready   t_in_word  (measured, target, feedforward)
// output    out        o_out_valid / i_out_ready t_out_word (drive, limit state)
// config    in         i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// A word within limits needs two gain products and a clamped word needs three;
// each of the three gain products is computed in the shared multiplier.
// One word is in flight; o_in_ready is high only while the sequencer is idle.
// The result register holds a finished word while the next one is accepted.
// Synchronous active-low reset clears the controller state and loads the register defaults.
module pi_controller_back_calc_antiwindup
    import pibc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_data,
    input  logic               i_cfg_we,
    input  logic [ADDR_W-1:0]  i_cfg_addr,
    input  logic [DATA_W-1:0]  i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_PROP_GO,
        S_PROP_WT,
        S_INC_GO,
        S_INC_WT,
        S_INTEG,
        S_SUM,
        S_CMP,
        S_WF_GO,
        S_WF_WT,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [MUL_B_W-1:0]        r_kp;
    logic [MUL_B_W-1:0]        r_ai;
    logic [MUL_B_W-1:0]        r_ka;
    logic signed [DATA_W-1:0]  r_upper;
    logic signed [DATA_W-1:0]  r_lower;

    logic signed [DATA_W-1:0]  r_meas;
    logic signed [DATA_W-1:0]  r_ref;
    logic signed [DATA_W-1:0]  r_ff;
    logic signed [DATA_W-1:0]  r_diff;
    logic signed [DATA_W-1:0]  r_err;
    logic signed [DATA_W-1:0]  r_prev_err;
    logic signed [DATA_W-1:0]  r_wf;
    logic signed [DATA_W-1:0]  r_prop;
    logic signed [INTEG_W-1:0] r_inc;
    logic signed [INTEG_W-1:0] r_isum;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [OVR_W-1:0]   r_over;
    logic signed [DATA_W-1:0]  r_drive;
    logic [LIM_W-1:0]          r_lim;
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic signed [DATA_W+1:0]  diff_w;
    logic signed [DATA_W+1:0]  err_w;
    logic signed [DATA_W:0]    err_pair;
    logic signed [INTEG_W:0]   isum_w;
    logic signed [OVR_W-1:0]   d_up;
    logic signed [OVR_W-1:0]   d_lo;
    logic                      above;
    logic                      below;
    t_mul_req                  mul_req;
    t_mul_rsp                  mul_rsp;

    pibc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign diff_w   = (DATA_W+2)'(r_ref) - (DATA_W+2)'(r_meas);
    assign err_w    = diff_w - (DATA_W+2)'(r_wf);
    assign err_pair = (DATA_W+1)'(r_err) + (DATA_W+1)'(r_prev_err);
    assign isum_w   = (INTEG_W+1)'(r_isum) + (INTEG_W+1)'(r_inc);
    assign d_up     = OVR_W'(r_sum) - OVR_W'(r_upper);
    assign d_lo     = OVR_W'(r_sum) - OVR_W'(r_lower);
    assign above    = !d_up[OVR_W-1] && (d_up != '0);
    assign below    = d_lo[OVR_W-1];

    always_comb begin
        mul_req = '0;
        case (r_state)
            S_PROP_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(r_diff);
                mul_req.b     = r_kp;
            end
            S_INC_GO: begin
                mul_req.start  = 1'b1;
                mul_req.a      = MUL_A_W'(err_pair);
                mul_req.b      = r_ai;
                mul_req.frac30 = 1'b1;
                mul_req.wide   = 1'b1;
            end
            S_WF_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(r_over);
                mul_req.b     = r_ka;
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= MUL_B_W'(1) << FRAC_BITS;
            r_ai    <= '0;
            r_ka    <= '0;
            r_upper <= {1'b0, {(DATA_W-1){1'b1}}};
            r_lower <= {1'b1, {(DATA_W-1){1'b0}}};
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PROP_GAIN:  r_kp    <= i_cfg_wdata;
                REG_INTEG_GAIN: r_ai    <= i_cfg_wdata;
                REG_AW_GAIN:    r_ka    <= i_cfg_wdata;
                REG_UPPER:      r_upper <= i_cfg_wdata;
                REG_LOWER:      r_lower <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_err  <= '0;
            r_isum      <= '0;
            r_wf        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_meas  <= i_in_data.measured_value;
                        r_ref   <= i_in_data.target_value;
                        r_ff    <= i_in_data.feedforward_term;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_diff  <= sat_data(diff_w);
                    r_err   <= sat_data(err_w);
                    r_state <= S_PROP_GO;
                end
                S_PROP_GO: r_state <= S_PROP_WT;
                S_PROP_WT: begin
                    if (mul_rsp.done) begin
                        r_prop  <= mul_rsp.result[DATA_W-1:0];
                        r_state <= S_INC_GO;
                    end
                end
                S_INC_GO: r_state <= S_INC_WT;
                S_INC_WT: begin
                    if (mul_rsp.done) begin
                        r_inc   <= mul_rsp.result;
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    r_isum     <= sat_integ(isum_w);
                    r_prev_err <= r_err;
                    r_state    <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= SUM_W'(r_prop) + SUM_W'(r_isum) + SUM_W'(r_ff);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (above) begin
                        r_drive <= r_upper;
                        r_lim   <= LIM_UPPER;
                        r_over  <= d_up;
                        r_state <= S_WF_GO;
                    end else if (below) begin
                        r_drive <= r_lower;
                        r_lim   <= LIM_LOWER;
                        r_over  <= d_lo;
                        r_state <= S_WF_GO;
                    end else begin
                        r_drive <= r_sum[DATA_W-1:0];
                        r_lim   <= LIM_NONE;
                        r_wf    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_WF_GO: r_state <= S_WF_WT;
                S_WF_WT: begin
                    if (mul_rsp.done) begin
                        r_wf    <= mul_rsp.result[DATA_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.drive_value <= r_drive;
                        r_out.limit_state <= r_lim;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == S_PROP_WT || r_state == S_INC_WT || r_state == S_WF_WT))
        else $error("multiplier result outside a wait state");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_ERR))
        else $error("accepted word did not start the sequence");

    a_upper_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.limit_state == LIM_UPPER) |-> (o_out_data.drive_value == r_upper))
        else $error("upper clamp drive differs from limit");

    a_lim_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.limit_state == LIM_NONE || o_out_data.limit_state == LIM_UPPER
                         || o_out_data.limit_state == LIM_LOWER))
        else $error("bad limit state code");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the PI controller with back-calculation anti-windup.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pibc_pkg::*;

    localparam int                CYCLE_LIMIT = 1_000_000;
    localparam int                SETTLE      = 40;
    localparam int                LONG_HOLD   = 400;
    localparam int                ADDR_TOP    = (1 << ADDR_W) - 1;
    localparam logic [DATA_W-1:0] MAX_Q       = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] MIN_Q       = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE_Q       = 32'h0001_0000;
    localparam logic [DATA_W-1:0] ALL_ONES    = 32'hffff_ffff;

    class pi_drive_checker;
        logic [DATA_W-1:0] kp;
        logic [DATA_W-1:0] ai_gain;
        logic [DATA_W-1:0] ka;
        longint            upper;
        longint            lower;
        longint            prev_err;
        longint            integ;
        longint            windup_fb;
        t_out_word         pending_drives[$];
        int                errors;

        function new();
            kp        = 32'h0001_0000;
            ai_gain   = '0;
            ka        = '0;
            upper     = 64'sh7fff_ffff;
            lower     = -64'sh8000_0000;
            prev_err  = 0;
            integ     = 0;
            windup_fb = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_PROP_GAIN:  kp = val;
                REG_INTEG_GAIN: ai_gain = val;
                REG_AW_GAIN:    ka = val;
                REG_UPPER:      upper = $signed(val);
                REG_LOWER:      lower = $signed(val);
                default: ;
            endcase
        endfunction

        function longint sat_to(longint v, int w);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function longint mul_floor_sat(longint a, logic [DATA_W-1:0] b, int sh, int w);
            logic signed [127:0] pa;
            logic signed [127:0] pb;
            logic signed [127:0] p;
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            pa = a;
            pb = {96'd0, b};
            hi = (128'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            p  = (pa * pb) >>> sh;
            if (p > hi) p = hi;
            else if (p < lo) p = lo;
            return p[63:0];
        endfunction

        function void predict_drive(t_in_word w);
            longint    meas;
            longint    tgt;
            longint    ff;
            longint    diff;
            longint    err;
            longint    prop;
            longint    inc;
            longint    total;
            t_out_word r;
            meas  = w.measured_value;
            tgt   = w.target_value;
            ff    = w.feedforward_term;
            diff  = sat_to(tgt - meas, DATA_W);
            err   = sat_to(tgt - meas - windup_fb, DATA_W);
            prop  = mul_floor_sat(diff, kp, FRAC_BITS, DATA_W);
            inc   = mul_floor_sat(err + prev_err, ai_gain, AI_FRAC, INTEG_W);
            integ = sat_to(integ + inc, INTEG_W);
            total = prop + integ + ff;
            if (total > upper) begin
                windup_fb     = mul_floor_sat(total - upper, ka, FRAC_BITS, DATA_W);
                r.drive_value = upper[DATA_W-1:0];
                r.limit_state = LIM_UPPER;
            end else if (total < lower) begin
                windup_fb     = mul_floor_sat(total - lower, ka, FRAC_BITS, DATA_W);
                r.drive_value = lower[DATA_W-1:0];
                r.limit_state = LIM_LOWER;
            end else begin
                windup_fb     = 0;
                r.drive_value = total[DATA_W-1:0];
                r.limit_state = LIM_NONE;
            end
            prev_err = err;
            pending_drives.push_back(r);
        endfunction

        function void check_drive(t_out_word got);
            t_out_word exp_w;
            if (pending_drives.size() == 0) begin
                errors++;
                $display("%0t: unexpected word drive %0d state %0d", $time,
                         got.drive_value, got.limit_state);
                return;
            end
            exp_w = pending_drives.pop_front();
            if (got.drive_value !== exp_w.drive_value) begin
                errors++;
                $display("%0t: drive_value expected %0d actual %0d", $time,
                         exp_w.drive_value, got.drive_value);
            end
            if (got.limit_state !== exp_w.limit_state) begin
                errors++;
                $display("%0t: limit_state expected %0d actual %0d", $time,
                         exp_w.limit_state, got.limit_state);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_word          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_word         o_out_data;
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_addr;
    logic [DATA_W-1:0] i_cfg_wdata;

    pi_drive_checker checker_sb;
    bit              hold_req = 1'b0;
    int              cycle_count = 0;
    longint          seg_target = 0;
    longint          meas_track = 0;
    int              seg_left = 0;

    pi_controller_back_calc_antiwindup dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) checker_sb.predict_drive(i_in_data);
            if (o_out_valid && i_out_ready) checker_sb.check_drive(o_out_data);
        end
    end

    initial begin : out_stall
        int mode;
        int run;
        int k;
        i_out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(10, 150);
            for (k = 0; k < run; k++) begin
                @(negedge i_clk);
                if (hold_req) begin
                    i_out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= $urandom_range(0, 1);
                        2: i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= (k % 5 != 4);
                    endcase
                end
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 2))
            0: return r;
            1: return r >>> $urandom_range(8, 20);
            default: begin
                case ($urandom_range(0, 4))
                    0: return MIN_Q;
                    1: return MAX_Q;
                    2: return '0;
                    3: return ALL_ONES;
                    default: return ONE_Q;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_word next_sample();
        t_in_word                 w;
        logic signed [DATA_W-1:0] r;
        longint                   m;
        if ($urandom_range(0, 3) == 0) begin
            w.measured_value   = pick_value();
            w.target_value     = pick_value();
            w.feedforward_term = pick_value();
            return w;
        end
        if (seg_left == 0) begin
            r          = $urandom;
            seg_target = ($urandom_range(0, 9) == 0) ? r : (r >>> $urandom_range(6, 12));
            seg_left   = $urandom_range(4, 40);
        end
        seg_left--;
        r = $urandom;
        m = meas_track + (seg_target - meas_track) / 8 + (r >>> 20);
        if (m > 64'sh7fff_ffff) m = 64'sh7fff_ffff;
        else if (m < -64'sh8000_0000) m = -64'sh8000_0000;
        meas_track = m;
        r = $urandom;
        w.measured_value   = m[DATA_W-1:0];
        w.target_value     = seg_target[DATA_W-1:0];
        w.feedforward_term = r >>> $urandom_range(12, 24);
        return w;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(t_in_word w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (checker_sb.pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        checker_sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic load_settings(logic [DATA_W-1:0] kp, logic [DATA_W-1:0] ai,
                                 logic [DATA_W-1:0] ka, logic [DATA_W-1:0] up,
                                 logic [DATA_W-1:0] lo);
        cfg_write(REG_PROP_GAIN, kp);
        cfg_write(REG_INTEG_GAIN, ai);
        cfg_write(REG_AW_GAIN, ka);
        cfg_write(REG_UPPER, up);
        cfg_write(REG_LOWER, lo);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_batch(int count, bit with_hold);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && sent < count) begin
                if (with_hold && sent == count / 2) hold_req = 1'b1;
                send_word(next_sample());
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        logic [DATA_W-1:0] up;
        logic [DATA_W-1:0] lo;
        int                ph;
        checker_sb  = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: unit gain, no integrator, full-range limits
        send_word(t_in_word'{'0, '0, '0});
        send_word(t_in_word'{MIN_Q, MAX_Q, '0});
        send_word(t_in_word'{MAX_Q, MIN_Q, '0});
        send_word(t_in_word'{MIN_Q, MAX_Q, MAX_Q});
        send_word(t_in_word'{MAX_Q, MIN_Q, MIN_Q});
        send_word(t_in_word'{ALL_ONES, 32'd1, ALL_ONES});
        send_word(t_in_word'{ONE_Q, -ONE_Q, ONE_Q});
        quiesce();

        // typical loop: clamp at both limits with feedback carried over
        load_settings(32'h0002_0000, 32'h1000_0000, ONE_Q, 32'h000a_0000, -32'h000a_0000);
        send_word(t_in_word'{'0, 32'h0003_0000, '0});
        send_word(t_in_word'{'0, 32'h0014_0000, '0});
        send_word(t_in_word'{'0, 32'h0014_0000, '0});
        send_word(t_in_word'{'0, -32'h0014_0000, '0});
        send_word(t_in_word'{'0, -32'h0014_0000, '0});
        send_word(t_in_word'{'0, '0, '0});
        quiesce();

        // crossed limits
        load_settings(ONE_Q, '0, ONE_Q, -ONE_Q, ONE_Q);
        send_word(t_in_word'{'0, 32'h0002_0000, '0});
        send_word(t_in_word'{'0, '0, '0});
        send_word(t_in_word'{'0, -32'h0002_0000, '0});
        quiesce();

        // zero gains, equal limits
        load_settings('0, '0, '0, '0, '0);
        send_word(t_in_word'{MAX_Q, MIN_Q, '0});
        send_word(t_in_word'{'0, '0, 32'd1});
        send_word(t_in_word'{'0, '0, ALL_ONES});
        quiesce();

        // largest gains; writes past the last register are dropped
        for (int i = REG_LOWER + 1; i <= ADDR_TOP; i++) cfg_write(ADDR_W'(i), $urandom);
        load_settings(ALL_ONES, ALL_ONES, ALL_ONES, MAX_Q, MIN_Q);
        send_word(t_in_word'{MIN_Q, MAX_Q, MAX_Q});
        send_word(t_in_word'{MIN_Q, MAX_Q, MAX_Q});
        send_word(t_in_word'{MAX_Q, MIN_Q, MIN_Q});
        send_word(t_in_word'{MAX_Q, MIN_Q, MIN_Q});
        send_word(t_in_word'{'0, '0, '0});
        quiesce();

        for (ph = 0; ph < 8; ph++) begin
            up = $urandom_range(ONE_Q, 64 * ONE_Q);
            lo = -$urandom_range(0, 64 * ONE_Q);
            case (ph)
                1: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
                4: load_settings(ALL_ONES, ALL_ONES, ALL_ONES, MAX_Q, MIN_Q);
                5: load_settings($urandom_range(0, 4 * ONE_Q), $urandom_range(0, 1 << 28),
                                 $urandom_range(0, 2 * ONE_Q), lo, up);
                default: load_settings($urandom_range(0, 4 * ONE_Q),
                                       $urandom_range(0, 1 << 28),
                                       $urandom_range(0, 2 * ONE_Q), up, lo);
            endcase
            send_batch(135, ph == 3);
            quiesce();
        end

        if (checker_sb.errors == 0 && checker_sb.pending_drives.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
